// ===== src/rgbrle_pkg.sv =====
package rgbrle_pkg;

    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned COLOR_W = 3 * CHAN_W;

    // Longest run one record can carry
    localparam logic [COUNT_W-1:0] RUN_MAX = 8'd255;

    // Result queue: one entry drains while up to two are written
    localparam int unsigned QUEUE_DEPTH = 3;
    localparam int unsigned PTR_W       = 2;
    localparam int unsigned LEVEL_W     = 2;

    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [LEVEL_W-1:0] level_t;

    typedef struct packed {
        logic [COUNT_W-1:0] run_length;
        logic [CHAN_W-1:0]  run_red;
        logic [CHAN_W-1:0]  run_green;
        logic [CHAN_W-1:0]  run_blue;
        logic               last_record;
    } record_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == ptr_t'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

endpackage

// ===== src/rgb_run_length_encoder_unit.sv =====
// RGB run-length encoder. Each accepted transaction on the s_ channel is one
// 24-bit pixel; the block extends the open run while the colour repeats, up
// to 255 pixels, and emits a record (length, red, green, blue) on the m_
// channel when the run closes. The pixel flagged s_last_pixel flushes the
// open run as a record with m_last_record set, so that pixel can produce two
// records. A pixel is taken every clock while s_ready is high; the rate is set
// by a three-entry result queue, which drops s_ready for one cycle after a
// pixel that produced two records while the downstream side takes one per
// clock. Each record is registered in the queue before it reaches the m_ channel.
module rgb_run_length_encoder_unit
    import rgbrle_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CHAN_W-1:0]   s_red,
    input  logic [CHAN_W-1:0]   s_green,
    input  logic [CHAN_W-1:0]   s_blue,
    input  logic                s_last_pixel,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [COUNT_W-1:0]  m_run_length,
    output logic [CHAN_W-1:0]   m_run_red,
    output logic [CHAN_W-1:0]   m_run_green,
    output logic [CHAN_W-1:0]   m_run_blue,
    output logic                m_last_record
);

    // Open run
    logic [COLOR_W-1:0] open_colour_reg, open_colour_next;
    logic [COUNT_W-1:0] open_count_reg,  open_count_next;
    logic               run_open_reg,    run_open_next;

    // Result queue
    record_t queue_mem [QUEUE_DEPTH];
    ptr_t    wr_ptr_reg, wr_ptr_next;
    ptr_t    rd_ptr_reg, rd_ptr_next;
    level_t  level_reg,  level_next;

    logic               accept;
    logic               pop;
    logic [COLOR_W-1:0] pix_colour;
    logic               extend;
    logic               close_run;
    logic [COLOR_W-1:0] cur_colour;
    logic [COUNT_W-1:0] cur_count;
    record_t            closed_rec;
    record_t            final_rec;
    record_t            slot0_rec;
    level_t             push_n;
    ptr_t               wr_ptr_second;

    assign s_ready = (level_reg <= level_t'(1));
    assign accept  = s_valid && s_ready;
    assign m_valid = (level_reg != '0);
    assign pop     = m_valid && m_ready;

    assign pix_colour = {s_red, s_green, s_blue};
    assign extend     = run_open_reg && (pix_colour == open_colour_reg)
                        && (open_count_reg != RUN_MAX);
    assign close_run  = run_open_reg && !extend;

    assign cur_colour = extend ? open_colour_reg : pix_colour;
    assign cur_count  = extend ? (open_count_reg + COUNT_W'(1)) : COUNT_W'(1);

    always_comb begin
        closed_rec.run_length  = open_count_reg;
        closed_rec.run_red     = open_colour_reg[COLOR_W-1 -: CHAN_W];
        closed_rec.run_green   = open_colour_reg[2*CHAN_W-1 -: CHAN_W];
        closed_rec.run_blue    = open_colour_reg[CHAN_W-1:0];
        closed_rec.last_record = 1'b0;

        final_rec.run_length   = cur_count;
        final_rec.run_red      = cur_colour[COLOR_W-1 -: CHAN_W];
        final_rec.run_green    = cur_colour[2*CHAN_W-1 -: CHAN_W];
        final_rec.run_blue     = cur_colour[CHAN_W-1:0];
        final_rec.last_record  = 1'b1;
    end

    // First written slot takes the closed run if there is one, else the flush
    assign slot0_rec     = close_run ? closed_rec : final_rec;
    assign wr_ptr_second = ptr_inc(wr_ptr_reg);

    always_comb begin
        push_n = '0;
        if (accept) begin
            push_n = level_t'(close_run) + level_t'(s_last_pixel);
        end
    end

    always_comb begin
        open_colour_next = open_colour_reg;
        open_count_next  = open_count_reg;
        run_open_next    = run_open_reg;
        if (accept) begin
            if (s_last_pixel) begin
                open_colour_next = '0;
                open_count_next  = '0;
                run_open_next    = 1'b0;
            end else begin
                open_colour_next = cur_colour;
                open_count_next  = cur_count;
                run_open_next    = 1'b1;
            end
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        case (push_n)
            level_t'(1): wr_ptr_next = wr_ptr_second;
            level_t'(2): wr_ptr_next = ptr_inc(wr_ptr_second);
            default:     wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        level_next  = level_reg + push_n - level_t'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_colour_reg <= '0;
            open_count_reg  <= '0;
            run_open_reg    <= 1'b0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            level_reg       <= '0;
        end else begin
            open_colour_reg <= open_colour_next;
            open_count_reg  <= open_count_next;
            run_open_reg    <= run_open_next;
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            level_reg       <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != '0) begin
            queue_mem[wr_ptr_reg] <= slot0_rec;
        end
        if (push_n == level_t'(2)) begin
            queue_mem[wr_ptr_second] <= final_rec;
        end
    end

    assign m_run_length  = queue_mem[rd_ptr_reg].run_length;
    assign m_run_red     = queue_mem[rd_ptr_reg].run_red;
    assign m_run_green   = queue_mem[rd_ptr_reg].run_green;
    assign m_run_blue    = queue_mem[rd_ptr_reg].run_blue;
    assign m_last_record = queue_mem[rd_ptr_reg].last_record;

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= level_t'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_open_count: assert property (@(posedge aclk) disable iff (!aresetn)
        run_open_reg == (open_count_reg != '0))
        else $error("run open flag disagrees with run length");

    a_flush_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_last_pixel |=> !run_open_reg && (level_reg != '0))
        else $error("frame end did not flush the open run");

    a_record_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_run_length != '0))
        else $error("empty run record emitted");

endmodule
